// File: rtl/core/wodo_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the wheel odometry block.
package wodo_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 8;
    localparam int TABLE_LEN         = 24;
    localparam int IPT_W             = 24;
    localparam logic [IPT_W-1:0] IPT_RESET = 24'd15252;
    localparam logic [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIST = 9'b000000010,
        S_PREP = 9'b000000100,
        S_NUM  = 9'b000001000,
        S_CORD = 9'b000010000,
        S_QSET = 9'b000100000,
        S_QMUL = 9'b001000000,
        S_WAIT = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    // atan(2^-j) as a 32-bit binary angle
    function automatic logic [29:0] atan_q32(input logic [4:0] j);
        logic [29:0] a;
        case (j)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/wodo_if.sv
// Channel interfaces: input items, result items and the configuration write.
interface wodo_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic signed [31:0] encoder_count;
    logic signed [11:0] heading;
    logic [31:0] time_us;
    modport source (output valid, command, encoder_count, heading, time_us, input ready);
    modport sink   (input valid, command, encoder_count, heading, time_us, output ready);
endinterface

interface wodo_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [23:0] step_x;
    logic signed [23:0] step_y;
    logic signed [31:0] velocity;
    logic        time_fault;
    modport source (output valid, pos_x, pos_y, step_x, step_y, velocity, time_fault,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, step_x, step_y, velocity, time_fault,
                    output ready);
endinterface

interface wodo_cfg_if;
    logic        valid;
    logic        ready;
    logic [wodo_pkg::IPT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/wodo_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module wodo_div #(
    parameter int NW = 68
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   w_trial;
    logic [32:0]   w_diff;

    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[31:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/core/wheel_odometry_integrator.sv
// Top level of the wheel odometry integrator: sequencer, serial multipliers and CORDIC.
//
// Usage:
//   i_item   : input items (command, encoder_count, heading, time_us), valid/ready.
//   o_result : one result item per input item (pos_x/y, step_x/y, velocity, time_fault).
//   i_cfg    : write of inch_per_tick_q24, always ready; write only while idle.
// An update item: bit-serial count scaling (S_DIST), two setup states (S_PREP, S_NUM),
//   then the velocity divider (DW+20 quotient bits, 60 at POS_FRAC_BITS=8) runs beside
//   CORDIC (CORDIC_STEPS) and the 32-bit serial resolve multiply; the divider is the
//   long pole, so an update item waits in S_WAIT until the divider is done.
// A reset item goes from accept straight to S_FIN: state is captured at accept, result is all zero.
// Throughput: one item at a time; ready is high only while the sequencer is idle.
//   The result sits in an output register, so the next item is accepted while a
//   result waits; a finished item waits in its last state only if that register is
//   still occupied.
// Reset (synchronous, active low): state and position clear, register returns to
//   1/1100 inch per tick, no result pending.
// A stalled receiver holds the result item stable until taken.
module wheel_odometry_integrator #(
    parameter int CORDIC_STEPS  = wodo_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = wodo_pkg::POS_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wodo_in_if.sink     i_item,
    wodo_out_if.source  o_result,
    wodo_cfg_if.sink    i_cfg
);
    localparam int S   = 24 - POS_FRAC_BITS;   // shift from Q24 product to position units
    localparam int PRW = 56;                   // 32 x 24 product
    localparam int DW  = PRW - S;              // signed distance width
    localparam int PW  = DW + 32;              // |dist| x |cos| product
    localparam int MW  = PW - 30;              // rounded magnitude
    localparam int SW  = MW + 1;               // signed step
    localparam int NW  = DW + 20;              // dividend |dist| x 1e6

    wodo_pkg::t_state r_state;

    logic [wodo_pkg::IPT_W-1:0] r_ipt;
    logic [31:0] r_zero, r_prevc, r_prevt, r_accx, r_accy, r_dt;
    logic [5:0]  r_cnt;
    logic        r_is_rst;
    logic [11:0] r_head;

    // count scaling: delta x register, one multiplier bit a cycle
    logic signed [PRW-1:0] r_mcand, r_prod;
    logic [wodo_pkg::IPT_W-1:0] r_mplier;
    logic signed [DW-1:0]  r_dist;
    logic [DW-1:0]         r_mag;

    // CORDIC
    logic signed [32:0] r_cx, r_cy;
    logic signed [33:0] r_cz;

    // resolve multiply
    logic [PW-1:0] r_ua, r_px, r_py;
    logic [31:0]   r_ucx, r_ucy;
    logic          r_negx, r_negy;

    logic [NW-1:0] r_num;

    // output register
    logic        r_ovalid;
    logic signed [31:0] r_opx, r_opy, r_ovel;
    logic signed [23:0] r_osx, r_osy;
    logic        r_ofault;

    logic          w_acc_item, w_div_start, w_div_done, w_load;
    logic [NW-1:0] w_quot;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == wodo_pkg::S_IDLE);
    assign w_acc_item   = i_item.valid && i_item.ready;
    assign w_div_start  = (r_state == wodo_pkg::S_CORD) && (r_cnt == '0);
    assign w_load       = (r_state == wodo_pkg::S_FIN) && (!r_ovalid || o_result.ready);

    wodo_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_dt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---- accept-time arithmetic ----
    logic [31:0] w_count, w_delta;
    assign w_count = i_item.encoder_count - r_zero;
    assign w_delta = w_count - r_prevc;

    // ---- distance rounding (half up, floor shift) ----
    logic signed [PRW-1:0] w_rsum;
    logic signed [DW-1:0]  w_dist;
    assign w_rsum = r_prod + (PRW'(1) <<< (S - 1));
    assign w_dist = w_rsum[PRW-1:S];

    // ---- CORDIC start: left half plane folds by half a turn ----
    logic        w_flip;
    logic [31:0] w_ang;
    assign w_flip = r_head[11] ^ r_head[10];
    assign w_ang  = {r_head, 20'd0} ^ {w_flip, 31'd0};

    logic signed [32:0] w_dx, w_dy;
    logic [29:0]        w_atan;
    assign w_dx   = r_cy >>> r_cnt[4:0];
    assign w_dy   = r_cx >>> r_cnt[4:0];
    assign w_atan = wodo_pkg::atan_q32(r_cnt[4:0]);

    // ---- final rounding, saturation, velocity ----
    logic [PW-1:0]        w_sumx, w_sumy;
    logic [MW-1:0]        w_mx, w_my;
    logic signed [SW-1:0] w_sx, w_sy;
    logic signed [23:0]   w_satx, w_saty;
    logic [31:0]          w_nax, w_nay;
    logic                 w_dneg;
    logic [NW-1:0]        w_lim, w_v;
    logic [31:0]          w_vel;
    logic                 w_fault;

    assign w_sumx = r_px + (PW'(1) << 29);
    assign w_sumy = r_py + (PW'(1) << 29);
    assign w_mx   = w_sumx[PW-1:30];
    assign w_my   = w_sumy[PW-1:30];
    assign w_sx   = r_negx ? -$signed({1'b0, w_mx}) : $signed({1'b0, w_mx});
    assign w_sy   = r_negy ? -$signed({1'b0, w_my}) : $signed({1'b0, w_my});

    always_comb begin
        if (w_sx > $signed(SW'(8388607)))       w_satx = 24'sh7FFFFF;
        else if (w_sx < -$signed(SW'(8388608))) w_satx = 24'sh800000;
        else                                    w_satx = w_sx[23:0];
        if (w_sy > $signed(SW'(8388607)))       w_saty = 24'sh7FFFFF;
        else if (w_sy < -$signed(SW'(8388608))) w_saty = 24'sh800000;
        else                                    w_saty = w_sy[23:0];
    end

    assign w_nax  = r_accx + w_sx[31:0];
    assign w_nay  = r_accy + w_sy[31:0];
    assign w_dneg = r_dist[DW-1];
    assign w_lim  = w_dneg ? NW'(33'h080000000) : NW'(33'h07FFFFFFF);
    assign w_v    = (w_quot > w_lim) ? w_lim : w_quot;
    assign w_fault = (r_dt == '0);

    always_comb begin
        if (w_fault) begin
            if (w_dneg)             w_vel = 32'h80000000;
            else if (r_dist != '0)  w_vel = 32'h7FFFFFFF;
            else                    w_vel = 32'h0;
        end else begin
            w_vel = w_dneg ? -w_v[31:0] : w_v[31:0];
        end
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipt <= wodo_pkg::IPT_RESET;
        end else if (i_cfg.valid) begin
            r_ipt <= i_cfg.data;
        end
    end

    // ---- sequencer and odometry state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wodo_pkg::S_IDLE;
            r_cnt    <= '0;
            r_zero   <= '0;
            r_prevc  <= '0;
            r_prevt  <= '0;
            r_accx   <= '0;
            r_accy   <= '0;
            r_is_rst <= 1'b0;
        end else begin
            case (r_state)
                wodo_pkg::S_IDLE: begin
                    if (w_acc_item) begin
                        r_cnt <= '0;
                        if (i_item.command) begin
                            r_zero   <= i_item.encoder_count;
                            r_prevc  <= '0;
                            r_prevt  <= i_item.time_us;
                            r_accx   <= '0;
                            r_accy   <= '0;
                            r_is_rst <= 1'b1;
                            r_state  <= wodo_pkg::S_FIN;
                        end else begin
                            r_prevc  <= w_count;
                            r_prevt  <= i_item.time_us;
                            r_is_rst <= 1'b0;
                            r_state  <= wodo_pkg::S_DIST;
                        end
                    end
                end
                wodo_pkg::S_DIST: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(wodo_pkg::IPT_W - 1)) r_state <= wodo_pkg::S_PREP;
                end
                wodo_pkg::S_PREP: r_state <= wodo_pkg::S_NUM;
                wodo_pkg::S_NUM: begin
                    r_cnt   <= '0;
                    r_state <= wodo_pkg::S_CORD;
                end
                wodo_pkg::S_CORD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) r_state <= wodo_pkg::S_QSET;
                end
                wodo_pkg::S_QSET: begin
                    r_cnt   <= '0;
                    r_state <= wodo_pkg::S_QMUL;
                end
                wodo_pkg::S_QMUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) r_state <= wodo_pkg::S_WAIT;
                end
                wodo_pkg::S_WAIT: begin
                    if (w_div_done) r_state <= wodo_pkg::S_FIN;
                end
                wodo_pkg::S_FIN: begin
                    if (w_load) begin
                        if (!r_is_rst) begin
                            r_accx <= w_nax;
                            r_accy <= w_nay;
                        end
                        r_state <= wodo_pkg::S_IDLE;
                    end
                end
                default: r_state <= wodo_pkg::S_IDLE;
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            wodo_pkg::S_IDLE: begin
                if (w_acc_item) begin
                    r_dt     <= i_item.time_us - r_prevt;
                    r_head   <= i_item.heading;
                    r_mcand  <= PRW'($signed(w_delta));
                    r_mplier <= r_ipt;
                    r_prod   <= '0;
                end
            end
            wodo_pkg::S_DIST: begin
                if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
            end
            wodo_pkg::S_PREP: begin
                r_dist <= w_dist;
                r_mag  <= w_dist[DW-1] ? DW'(-w_dist) : DW'(w_dist);
                r_cx   <= w_flip ? -wodo_pkg::GAIN_Q30 : wodo_pkg::GAIN_Q30;
                r_cy   <= '0;
                r_cz   <= 34'($signed(w_ang));
            end
            wodo_pkg::S_NUM: begin
                r_num <= NW'({20'd0, r_mag} * NW'(wodo_pkg::USEC_PER_SEC));
                r_ua  <= PW'(r_mag);
            end
            wodo_pkg::S_CORD: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - $signed({4'd0, w_atan});
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + $signed({4'd0, w_atan});
                end
            end
            wodo_pkg::S_QSET: begin
                r_ucx  <= r_cx[32] ? 32'(-r_cx) : r_cx[31:0];
                r_ucy  <= r_cy[32] ? 32'(-r_cy) : r_cy[31:0];
                r_negx <= w_dneg ^ r_cx[32];
                r_negy <= w_dneg ^ r_cy[32];
                r_px   <= '0;
                r_py   <= '0;
            end
            wodo_pkg::S_QMUL: begin
                if (r_ucx[0]) r_px <= r_px + r_ua;
                if (r_ucy[0]) r_py <= r_py + r_ua;
                r_ua  <= r_ua << 1;
                r_ucx <= r_ucx >> 1;
                r_ucy <= r_ucy >> 1;
            end
            default: begin
            end
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_is_rst) begin
                r_opx    <= '0;
                r_opy    <= '0;
                r_osx    <= '0;
                r_osy    <= '0;
                r_ovel   <= '0;
                r_ofault <= 1'b0;
            end else begin
                r_opx    <= w_nax;
                r_opy    <= w_nay;
                r_osx    <= w_satx;
                r_osy    <= w_saty;
                r_ovel   <= w_vel;
                r_ofault <= w_fault;
            end
        end
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.pos_x      = r_opx;
    assign o_result.pos_y      = r_opy;
    assign o_result.step_x     = r_osx;
    assign o_result.step_y     = r_osy;
    assign o_result.velocity   = r_ovel;
    assign o_result.time_fault = r_ofault;

    // ---- assertions ----
    a_rst_item_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_item && i_item.command) |=> (r_state == wodo_pkg::S_FIN))
        else $error("reset item did not go straight to finish");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_result.valid)
        else $error("finished item not presented");

    a_div_before_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wodo_pkg::S_FIN) && !r_is_rst) |-> w_div_done)
        else $error("update finished before divider");

    a_fault_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.time_fault) |->
        (o_result.velocity == 32'sh7FFFFFFF || o_result.velocity == 32'sh80000000 ||
         o_result.velocity == 32'sh0))
        else $error("time fault with unsaturated velocity");

endmodule

// File: tb/wodo_checker.sv
// Odometry checker: watches the channels, predicts each result item and compares it.
module wodo_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wodo_in_if     mon_in,
    wodo_out_if    mon_out,
    wodo_cfg_if    mon_cfg,
    output int     o_errors,
    output int     o_pending,
    output int     o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = wodo_pkg::CORDIC_STEPS_DEF;
    localparam int SHIFT = 24 - wodo_pkg::POS_FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [23:0] step_x;
        logic signed [23:0] step_y;
        logic signed [31:0] velocity;
        logic               time_fault;
    } t_odo_result;

    t_odo_result odo_expect_q[$];

    logic [wodo_pkg::IPT_W-1:0] ipt_q24;
    logic [31:0] zero_off, last_count, last_time, sum_x, sum_y;

    // round(a * c / 2^30), ties away from zero, same split as the block uses
    function automatic longint round_q30(longint a, longint c);
        bit neg;
        longint unsigned ua, uc, hi, lo, m;
        neg = (a < 0) != (c < 0);
        ua = (a < 0) ? -a : a;
        uc = (c < 0) ? -c : c;
        hi = (ua >> 24) * uc;
        lo = (ua & 64'hFFFFFF) * uc;
        m = (hi >> 6) + ((((hi & 64'd63) << 24) + lo + (64'd1 << 29)) >> 30);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint speed_of(longint span, logic [31:0] dt);
        bit neg;
        longint unsigned ud, lim, q, r, v;
        neg = span < 0;
        ud = neg ? -span : span;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        q = ud / dt;
        r = ud % dt;
        if (q >= 2148) v = lim;
        else v = q * 1000000 + (r * 1000000) / dt;
        if (v > lim) v = lim;
        return neg ? -longint'(v) : longint'(v);
    endfunction

    // Advances the odometry state by one input item and returns its result.
    function automatic t_odo_result odometry_step(logic cmd, logic [31:0] enc,
                                                  logic [11:0] hd, logic [31:0] now);
        t_odo_result res;
        logic [31:0] count, ang, dt;
        longint delta, travel, x, y, z, nx, dx, dy, sx, sy, vel;
        res = '{default: '0};
        if (cmd) begin
            zero_off = enc;
            last_count = '0;
            last_time = now;
            sum_x = '0;
            sum_y = '0;
            return res;
        end
        count = enc - zero_off;
        delta = longint'(signed'(count - last_count));
        travel = (delta * longint'(ipt_q24) + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
        ang = {hd, 20'b0};
        x = longint'(signed'(wodo_pkg::GAIN_Q30));
        y = 0;
        // left half plane: flip start vector, turn angle back by half a turn
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
            x = -x;
            ang = ang - 32'h80000000;
        end
        z = longint'(signed'(ang));
        for (int j = 0; j < STEPS && j < wodo_pkg::TABLE_LEN; j++) begin
            dx = y >>> j;
            dy = x >>> j;
            if (z >= 0) begin
                nx = x - dx; y = y + dy; z = z - longint'(wodo_pkg::atan_q32(j[4:0]));
            end else begin
                nx = x + dx; y = y - dy; z = z + longint'(wodo_pkg::atan_q32(j[4:0]));
            end
            x = nx;
        end
        sx = round_q30(travel, x);
        sy = round_q30(travel, y);
        sum_x = sum_x + sx[31:0];
        sum_y = sum_y + sy[31:0];
        dt = now - last_time;
        if (dt == 0) begin
            res.time_fault = 1'b1;
            vel = travel > 0 ? 64'sd2147483647 : (travel < 0 ? -64'sd2147483648 : 0);
        end else begin
            vel = speed_of(travel, dt);
        end
        last_count = count;
        last_time = now;
        res.pos_x = sum_x;
        res.pos_y = sum_y;
        res.step_x = 24'(clip24(sx));
        res.step_y = 24'(clip24(sy));
        res.velocity = vel[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_odo_result got, want;
        bit bad;
        if (!i_rst_n) begin
            ipt_q24 = wodo_pkg::IPT_RESET;
            zero_off = '0; last_count = '0; last_time = '0; sum_x = '0; sum_y = '0;
            odo_expect_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (mon_out.valid && mon_out.ready) begin
                got.pos_x = mon_out.pos_x;
                got.pos_y = mon_out.pos_y;
                got.step_x = mon_out.step_x;
                got.step_y = mon_out.step_y;
                got.velocity = mon_out.velocity;
                got.time_fault = mon_out.time_fault;
                o_results <= o_results + 1;
                if (odo_expect_q.size() == 0) begin
                    $error("result item with no item outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    want = odo_expect_q.pop_front();
                    bad = 1'b0;
                    if (got.pos_x != want.pos_x) begin
                        $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x);
                        bad = 1'b1;
                    end
                    if (got.pos_y != want.pos_y) begin
                        $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y);
                        bad = 1'b1;
                    end
                    if (got.step_x != want.step_x) begin
                        $error("step_x exp %0d got %0d", want.step_x, got.step_x);
                        bad = 1'b1;
                    end
                    if (got.step_y != want.step_y) begin
                        $error("step_y exp %0d got %0d", want.step_y, got.step_y);
                        bad = 1'b1;
                    end
                    if (got.velocity != want.velocity) begin
                        $error("velocity exp %0d got %0d", want.velocity, got.velocity);
                        bad = 1'b1;
                    end
                    if (got.time_fault != want.time_fault) begin
                        $error("time_fault exp %0d got %0d", want.time_fault,
                               got.time_fault);
                        bad = 1'b1;
                    end
                    if (bad) o_errors <= o_errors + 1;
                end
            end
            if (mon_in.valid && mon_in.ready)
                odo_expect_q.push_back(odometry_step(mon_in.command, mon_in.encoder_count,
                                                     mon_in.heading, mon_in.time_us));
            if (mon_cfg.valid && mon_cfg.ready)
                ipt_q24 = mon_cfg.data;
        end
        o_pending <= odo_expect_q.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus for the odometry integrator and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PER_PHASE = 250;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int DRAIN_CYCLES   = 150;   // longer than an update item takes

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   n_sent;
    int   cycles;

    // Software copy of the last count and time, so sequences stay plausible.
    logic [31:0] cur_enc, cur_time;

    wodo_in_if  item_ch ();
    wodo_out_if result_ch ();
    wodo_cfg_if cfg_ch ();

    wheel_odometry_integrator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    wodo_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .mon_in    (item_ch),
        .mon_out   (result_ch),
        .mon_cfg   (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly back to back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(5, 1);
        return $urandom_range(200, 20);
    endfunction

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls; once, a long hold-off while the sender keeps going
    // so the output register fills and the block stops taking items.
    initial begin
        bit held;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 400) begin
                held = 1'b1;
                result_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            // long runs with no stall at all in the middle phase
            if (n_sent > 700 && n_sent < 900) result_ch.ready = 1'b1;
            else result_ch.ready = (pick_gap() == 0);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] enc, logic [11:0] hd,
                             logic [31:0] now);
        item_ch.command = cmd;
        item_ch.encoder_count = enc;
        item_ch.heading = hd;
        item_ch.time_us = now;
        item_ch.valid = 1'b1;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        n_sent++;
        cur_enc = enc;
        cur_time = now;
        repeat (pick_gap()) @(negedge i_clk);
    endtask

    // Sender pauses until every result item is back, then lets the block settle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ipt(logic [wodo_pkg::IPT_W-1:0] val);
        drain();
        cfg_ch.data = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random updates with the odd reset; most steps are small moves forward in time.
    task automatic random_phase(int count);
        int r;
        logic [31:0] enc, now;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            enc = cur_enc + $urandom_range(4000) - 2000;
            now = cur_time + $urandom_range(20000, 1);
            if (r < 5) enc = $urandom;                       // wild jump in count
            else if (r < 10) now = $urandom;                 // wild jump in time
            else if (r < 14) now = cur_time;                 // no time elapsed
            else if (r < 18) enc = cur_enc + ($urandom & 32'h00FFFFFF);
            if (r >= 95) send_item(1'b1, $urandom, 12'($urandom), $urandom);
            else send_item(1'b0, enc, 12'($urandom), now);
        end
    endtask

    initial begin
        logic [11:0] hds[8];
        i_rst_n = 1'b0;
        n_sent = 0;
        cur_enc = '0;
        cur_time = '0;
        item_ch.valid = 1'b0;
        item_ch.command = 1'b0;
        item_ch.encoder_count = '0;
        item_ch.heading = '0;
        item_ch.time_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: headings at axes, half turns and extremes, at the reset register.
        hds = '{12'h800, 12'h7FF, 12'h000, 12'h400, 12'hC00, 12'h200, 12'hA00, 12'h5FF};
        send_item(1'b0, 32'd1100, 12'h000, 32'd1000);          // update before any reset
        send_item(1'b1, 32'h7FFFFFFF, 12'h7FF, 32'hFFFFFF00);   // reset at max count
        foreach (hds[k])
            send_item(1'b0, cur_enc + 32'd5000, hds[k], cur_time + 32'd100); // time wraps
        send_item(1'b0, cur_enc - 32'd9000, 12'h123, cur_time);  // zero elapsed, negative
        send_item(1'b0, cur_enc, 12'h123, cur_time);             // zero elapsed, no move
        send_item(1'b0, cur_enc + 32'd10, 12'h123, cur_time);    // zero elapsed, positive
        send_item(1'b0, 32'h80000000, 12'h800, cur_time + 32'd1); // huge delta, dt of one
        send_item(1'b0, 32'h7FFFFFFF, 12'h000, 32'hFFFFFFFF);
        send_item(1'b1, 32'h80000000, 12'h000, 32'h0);
        random_phase(RAND_PER_PHASE);

        // Largest scale: steps saturate, accumulators wrap.
        write_ipt(24'hFFFFFF);
        send_item(1'b0, cur_enc + 32'h7FFFFFFF, 12'h000, cur_time + 32'd3);
        send_item(1'b0, cur_enc + 32'h80000000, 12'h400, cur_time + 32'd3);
        random_phase(RAND_PER_PHASE);

        write_ipt(24'd1);
        random_phase(RAND_PER_PHASE);

        write_ipt(24'($urandom_range(24'hFFFFFF, 1)));
        random_phase(RAND_PER_PHASE);

        write_ipt(wodo_pkg::IPT_RESET);
        random_phase(RAND_PER_PHASE);

        drain();
        $display("sent %0d items, %0d result items checked, 5 scale settings",
                 n_sent, results);
        $display("covered min/max scale, saturation, zero elapsed time, resets, stalls");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
